FILE: design/hmac_pkg.sv
// hmac_pkg: types, codes and SHA-256 constants for the HMAC-SHA256 engine.
// Used by hmac_sha_core and hmac_sha256_engine. No dependencies.
package hmac_pkg;

  typedef enum logic [1:0] {
    CMD_KEY = 2'd0,
    CMD_MSG = 2'd1,
    CMD_FIN = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KRAW,
    ST_BYTE,
    ST_KPAD,
    ST_DIG,
    ST_P80,
    ST_PZERO,
    ST_PLEN,
    ST_PWAIT,
    ST_OUT
  } eng_state_t;

  typedef enum logic [1:0] {
    FIN_KEY,
    FIN_INNER,
    FIN_MAC
  } fin_sel_t;

  typedef enum logic [1:0] {
    CP_IDLE,
    CP_ROUND,
    CP_FOLD
  } core_phase_t;

  typedef struct packed {
    logic       start;
    logic       absorb;
    logic [7:0] data;
  } core_req_t;

  typedef struct packed {
    logic         ready;
    logic [5:0]   fill;
    logic [255:0] digest;
  } core_rsp_t;

  localparam logic [7:0] IPAD      = 8'h36;
  localparam logic [7:0] OPAD      = 8'h5c;
  localparam logic [7:0] PAD_FIRST = 8'h80;
  localparam logic [5:0] LEN_FILL  = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

FILE: design/hmac_sha_core.sv
// hmac_sha_core: SHA-256 byte absorber with one compression round per cycle.
// Depends on hmac_pkg. Padding and length are supplied by the caller as bytes.
module hmac_sha_core (
  input  logic                clk,
  input  logic                rst,
  input  hmac_pkg::core_req_t req,
  output hmac_pkg::core_rsp_t rsp
);
  import hmac_pkg::*;

  core_phase_t phase;
  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [511:0] blk;
  logic [511:0] blk_next;
  logic [5:0]  fill;
  logic [5:0]  round;
  logic [31:0] t1, t2, s0, s1, w_new;
  logic        take;

  assign take     = req.absorb && (phase == CP_IDLE);
  assign blk_next = {blk[503:0], req.data};

  always_comb begin
    t1 = v[7] + ({v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^
                 {v[4][24:0], v[4][31:25]}) +
         ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round) + w[0];
    t2 = ({v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^
          {v[0][21:0], v[0][31:22]}) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ {3'b000, w[1][31:3]};
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^
         {10'd0, w[14][31:10]};
    w_new = w[0] + s0 + w[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= CP_IDLE;
      fill  <= '0;
      round <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
    end else begin
      unique case (phase)
        CP_IDLE: begin
          if (req.start) begin
            fill <= '0;
            for (int i = 0; i < 8; i++) chain[i] <= IV[i];
          end else if (take) begin
            blk  <= blk_next;
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              for (int i = 0; i < 16; i++) w[i] <= blk_next[511 - 32*i -: 32];
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
              round <= '0;
              phase <= CP_ROUND;
            end
          end
        end
        CP_ROUND: begin
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          round <= round + 6'd1;
          if (round == 6'd63) phase <= CP_FOLD;
        end
        CP_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          phase <= CP_IDLE;
        end
        default: phase <= CP_IDLE;
      endcase
    end
  end

  assign rsp.ready  = (phase == CP_IDLE);
  assign rsp.fill   = fill;
  assign rsp.digest = {chain[0], chain[1], chain[2], chain[3],
                       chain[4], chain[5], chain[6], chain[7]};

endmodule

FILE: design/hmac_sha256_engine.sv
// hmac_sha256_engine: streaming HMAC-SHA256 top level with byte sequencer.
// Depends on hmac_pkg and hmac_sha_core.
// A short key byte is stored while idle; a message byte passes through ST_BYTE; each full
// 64-byte block keeps the shared compression unit busy for its 64 rounds and the fold.
// Finish in message phase: inner pad, outer key pad, digest and pad precede the MAC
// request, later if a block is compressing; an open or long key adds its own pad and tail.
// Reset: synchronous; clears key, counters and chain to the SHA-256 start values.
module hmac_sha256_engine (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser,  // [1:0] cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata   // mac_word0, mac_word1, mac_word2, mac_word3
);
  import hmac_pkg::*;

  eng_state_t   state, state_next;
  fin_sel_t     fin_sel, fin_sel_next;
  cmd_t         hold_cmd, hold_cmd_next;
  logic [7:0]   hold_b, hold_b_next;
  logic [5:0]   cnt, cnt_next;
  logic [511:0] key, key_next;
  logic [6:0]   kc, kc_next;
  logic         long_key, long_key_next;
  logic         phase, phase_next;
  logic         opad, opad_next;
  logic [63:0]  total, total_next;
  logic [63:0]  lenbits, lenbits_next;
  logic [255:0] inner, inner_next;
  logic         out_valid, out_valid_next;
  logic [255:0] out_data, out_data_next;
  core_req_t    core_req;
  core_rsp_t    core_rsp;
  logic         acc;

  hmac_sha_core u_core (
    .clk (clk),
    .rst (rst),
    .req (core_req),
    .rsp (core_rsp)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fin_sel   <= FIN_KEY;
      cnt       <= '0;
      key       <= '0;
      kc        <= '0;
      long_key  <= 1'b0;
      phase     <= 1'b0;
      opad      <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
      hold_cmd  <= CMD_NOP;
    end else begin
      state     <= state_next;
      fin_sel   <= fin_sel_next;
      cnt       <= cnt_next;
      key       <= key_next;
      kc        <= kc_next;
      long_key  <= long_key_next;
      phase     <= phase_next;
      opad      <= opad_next;
      total     <= total_next;
      out_valid <= out_valid_next;
      hold_cmd  <= hold_cmd_next;
    end
    hold_b   <= hold_b_next;
    lenbits  <= lenbits_next;
    inner    <= inner_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    fin_sel_next   = fin_sel;
    hold_cmd_next  = hold_cmd;
    hold_b_next    = hold_b;
    cnt_next       = cnt;
    key_next       = key;
    kc_next        = kc;
    long_key_next  = long_key;
    phase_next     = phase;
    opad_next      = opad;
    total_next     = total;
    lenbits_next   = lenbits;
    inner_next     = inner;
    out_data_next  = out_data;
    out_valid_next = out_valid && !m_axis_tready;
    core_req       = '0;

    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          hold_b_next   = s_axis_tdata;
          hold_cmd_next = cmd_t'(s_axis_tuser);
          unique case (cmd_t'(s_axis_tuser))
            CMD_KEY: begin
              if (!phase) begin
                if (long_key) begin
                  state_next = ST_BYTE;
                end else if (!kc[6]) begin
                  key_next[9'd511 - {kc[5:0], 3'b000} -: 8] = s_axis_tdata;
                  kc_next = kc + 7'd1;
                end else begin
                  core_req.start = 1'b1;
                  total_next     = '0;
                  cnt_next       = '0;
                  state_next     = ST_KRAW;
                end
              end
            end
            CMD_MSG, CMD_FIN: begin
              if (phase) begin
                if (cmd_t'(s_axis_tuser) == CMD_MSG) begin
                  state_next = ST_BYTE;
                end else begin
                  fin_sel_next = FIN_INNER;
                  state_next   = ST_P80;
                end
              end else if (long_key) begin
                fin_sel_next = FIN_KEY;
                state_next   = ST_P80;
              end else begin
                core_req.start = 1'b1;
                total_next     = '0;
                cnt_next       = '0;
                opad_next      = 1'b0;
                state_next     = ST_KPAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_KRAW: begin
        core_req.absorb = 1'b1;
        core_req.data   = key[511:504];
        if (core_rsp.ready) begin
          key_next   = {key[503:0], key[511:504]};
          total_next = total + 64'd1;
          cnt_next   = cnt + 6'd1;
          if (cnt == 6'd63) begin
            long_key_next = 1'b1;
            state_next    = ST_BYTE;
          end
        end
      end
      ST_BYTE: begin
        core_req.absorb = 1'b1;
        core_req.data   = hold_b;
        if (core_rsp.ready) begin
          total_next = total + 64'd1;
          state_next = ST_IDLE;
        end
      end
      ST_KPAD: begin
        core_req.absorb = 1'b1;
        core_req.data   = key[511:504] ^ (opad ? OPAD : IPAD);
        if (core_rsp.ready) begin
          key_next   = {key[503:0], key[511:504]};
          total_next = total + 64'd1;
          cnt_next   = cnt + 6'd1;
          if (cnt == 6'd63) begin
            if (opad) begin
              state_next = ST_DIG;
            end else begin
              phase_next = 1'b1;
              if (hold_cmd == CMD_MSG) begin
                state_next = ST_BYTE;
              end else begin
                fin_sel_next = FIN_INNER;
                state_next   = ST_P80;
              end
            end
          end
        end
      end
      ST_DIG: begin
        core_req.absorb = 1'b1;
        core_req.data   = inner[255:248];
        if (core_rsp.ready) begin
          inner_next = {inner[247:0], 8'h00};
          total_next = total + 64'd1;
          cnt_next   = cnt + 6'd1;
          if (cnt == 6'd31) begin
            fin_sel_next = FIN_MAC;
            state_next   = ST_P80;
          end
        end
      end
      ST_P80: begin
        core_req.absorb = 1'b1;
        core_req.data   = PAD_FIRST;
        if (core_rsp.ready) begin
          lenbits_next = {total[60:0], 3'b000};
          state_next   = ST_PZERO;
        end
      end
      ST_PZERO: begin
        if (core_rsp.fill == LEN_FILL && core_rsp.ready) begin
          cnt_next   = '0;
          state_next = ST_PLEN;
        end else begin
          core_req.absorb = 1'b1;
          core_req.data   = 8'h00;
        end
      end
      ST_PLEN: begin
        core_req.absorb = 1'b1;
        core_req.data   = lenbits[63:56];
        if (core_rsp.ready) begin
          lenbits_next = {lenbits[55:0], 8'h00};
          cnt_next     = cnt + 6'd1;
          if (cnt == 6'd7) state_next = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (core_rsp.ready) begin
          cnt_next = '0;
          unique case (fin_sel)
            FIN_KEY: begin
              key_next       = {core_rsp.digest, 256'd0};
              kc_next        = 7'd32;
              core_req.start = 1'b1;
              total_next     = '0;
              opad_next      = 1'b0;
              state_next     = ST_KPAD;
            end
            FIN_INNER: begin
              inner_next     = core_rsp.digest;
              core_req.start = 1'b1;
              total_next     = '0;
              opad_next      = 1'b1;
              state_next     = ST_KPAD;
            end
            default: begin
              inner_next = core_rsp.digest;
              state_next = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {inner[63:0], inner[127:64], inner[191:128], inner[255:192]};
          key_next       = '0;
          kc_next        = '0;
          long_key_next  = 1'b0;
          phase_next     = 1'b0;
          core_req.start = 1'b1;
          total_next     = '0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: design/hmac_checker.sv
// hmac_checker: port-level checks for hmac_sha256_engine, bound to the top.
// Depends on hmac_pkg and the hmac_sha256_engine ports.
module hmac_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [7:0]   s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata
);
  import hmac_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result request dropped or changed while stalled");

  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_FIN |=> !s_axis_tready)
    else $error("finish request did not start MAC computation");

  a_key_no_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_KEY |=> !$rose(m_axis_tvalid))
    else $error("key request produced a result");

  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result request right after reset");

endmodule

bind hmac_sha256_engine hmac_checker u_hmac_checker (.*);

FILE: bench/hmac_mac_checker.sv
// hmac_mac_checker: watches the request and MAC channels of hmac_sha256_engine,
// predicts each MAC with its own HMAC-SHA256 model and compares. Depends on hmac_pkg.
`timescale 1ns / 1ps
module hmac_mac_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [255:0] m_axis_tdata,
  output int           fail_count,
  output int           macs_pending
);
  import hmac_pkg::*;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [7:0]   key_mem [64];
  int           key_len;
  bit           key_hashing;
  logic [31:0]  hv [8];
  logic [7:0]   blk [64];
  int           blk_fill;
  logic [63:0]  byte_cnt;
  bit           in_msg;
  logic [255:0] mac_queue [$];

  assign macs_pending = mac_queue.size();

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) a[i] = hv[i];
    for (int i = 0; i < 64; i++) begin
      t1 = a[7] + (ror(a[4], 6) ^ ror(a[4], 11) ^ ror(a[4], 25))
         + ((a[4] & a[5]) ^ (~a[4] & a[6])) + RK[i] + w[i];
      t2 = (ror(a[0], 2) ^ ror(a[0], 13) ^ ror(a[0], 22))
         + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
      a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
      a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] = hv[i] + a[i];
  endfunction

  function automatic void sha_init();
    for (int i = 0; i < 8; i++) hv[i] = IV[i];
    blk_fill = 0;
    byte_cnt = '0;
  endfunction

  function automatic void sha_byte(logic [7:0] b);
    blk[blk_fill] = b;
    blk_fill = (blk_fill + 1) % 64;
    byte_cnt = byte_cnt + 1;
    if (blk_fill == 0) compress_block();
  endfunction

  function automatic logic [255:0] sha_digest();
    logic [63:0] bits;
    logic [255:0] d;
    bits = byte_cnt << 3;
    blk[blk_fill] = PAD_FIRST;
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin blk[blk_fill] = 8'h00; blk_fill++; end
      compress_block();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin blk[blk_fill] = 8'h00; blk_fill++; end
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress_block();
    blk_fill = 0;
    for (int i = 0; i < 8; i++) d[255-32*i -: 32] = hv[i];
    return d;
  endfunction

  function automatic void model_clear();
    for (int i = 0; i < 64; i++) key_mem[i] = 8'h00;
    key_len = 0;
    key_hashing = 0;
    in_msg = 0;
    sha_init();
  endfunction

  function automatic void absorb_key_pad(logic [7:0] pad);
    for (int i = 0; i < 64; i++) sha_byte(key_mem[i] ^ pad);
  endfunction

  function automatic void close_key();
    logic [255:0] d;
    if (key_hashing) begin
      d = sha_digest();
      for (int i = 0; i < 64; i++) key_mem[i] = (i < 32) ? d[255-8*i -: 8] : 8'h00;
      key_len = 32;
    end
    sha_init();
    absorb_key_pad(IPAD);
    in_msg = 1;
  endfunction

  function automatic void predict_request(cmd_t c, logic [7:0] b);
    logic [255:0] inner, mac;
    case (c)
      CMD_KEY: begin
        if (!in_msg) begin
          if (key_hashing) sha_byte(b);
          else if (key_len < 64) begin
            key_mem[key_len] = b;
            key_len++;
          end else begin
            sha_init();
            for (int i = 0; i < 64; i++) sha_byte(key_mem[i]);
            sha_byte(b);
            key_hashing = 1;
          end
        end
      end
      CMD_MSG: begin
        if (!in_msg) close_key();
        sha_byte(b);
      end
      CMD_FIN: begin
        if (!in_msg) close_key();
        inner = sha_digest();
        sha_init();
        absorb_key_pad(OPAD);
        for (int i = 0; i < 32; i++) sha_byte(inner[255-8*i -: 8]);
        mac = sha_digest();
        // word0 = MAC bytes 0..7 in the low 64 bits
        mac_queue.push_back({mac[63:0], mac[127:64], mac[191:128], mac[255:192]});
        model_clear();
      end
      default: ;
    endcase
  endfunction

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  logic [255:0] want;

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      model_clear();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mac_queue.size() == 0) begin
          report("MAC with no request pending");
        end else begin
          want = mac_queue.pop_front();
          for (int k = 0; k < 4; k++)
            if (m_axis_tdata[64*k +: 64] !== want[64*k +: 64])
              report($sformatf("mac_word%0d got %h want %h", k,
                               m_axis_tdata[64*k +: 64], want[64*k +: 64]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_request(cmd_t'(s_axis_tuser), s_axis_tdata);
    end
  end

endmodule

FILE: bench/tb_top.sv
// tb_top: stimulus and verdict for hmac_sha256_engine; MAC checking is done
// by hmac_mac_checker. Depends on hmac_pkg, the engine and the checker.
`timescale 1ns / 1ps
module tb_top;
  import hmac_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = CMD_NOP;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [255:0] m_axis_tdata;
  int           fail_count;
  int           macs_pending;
  int           sent = 0;
  bit           burst_mode = 0;
  bit           hold_request = 0;
  bit           no_stall = 0;

  always #5 clk = ~clk;

  hmac_sha256_engine dut (.*);
  hmac_mac_checker chk (.*);

  task automatic send(cmd_t c, logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // one MAC: key bytes and message bytes, with occasional stray requests if noisy, finish
  task automatic mac_run(int klen, int mlen, bit noisy);
    for (int i = 0; i < klen; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send(CMD_NOP, pick_byte());
      send(CMD_KEY, pick_byte());
    end
    for (int i = 0; i < mlen; i++) begin
      send(CMD_MSG, pick_byte());
      if (noisy && $urandom_range(0, 11) == 0)
        send($urandom_range(0, 1) ? CMD_NOP : CMD_KEY, pick_byte());
    end
    send(CMD_FIN, pick_byte());
  endtask

  always begin
    int n;
    n = no_stall ? 0 : $urandom_range(0, 9);
    if (hold_request) begin
      m_axis_tready <= 0;
      repeat (3000) @(posedge clk);
      hold_request = 0;
    end else if (n > 0) begin
      m_axis_tready <= 0;
      repeat (n) @(posedge clk);
    end
    m_axis_tready <= 1;
    @(posedge clk);
    while (!m_axis_tvalid) @(posedge clk);
  end

  initial begin
    int klen, mlen, runs;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: unused command, empty message, extremes, key byte during message
    send(CMD_NOP, 8'hff);
    send(CMD_FIN, 8'hff);
    send(CMD_KEY, 8'hff);
    send(CMD_KEY, 8'h00);
    send(CMD_MSG, 8'h00);
    send(CMD_KEY, 8'hff);
    send(CMD_NOP, 8'h00);
    send(CMD_MSG, 8'hff);
    send(CMD_FIN, 8'h00);
    send(CMD_KEY, 8'h5a);
    send(CMD_FIN, 8'ha5);

    runs = 0;
    while (sent < 1850) begin
      runs++;
      burst_mode = ($urandom_range(0, 5) == 0);
      no_stall   = ($urandom_range(0, 5) == 0);
      if (runs == 6) hold_request = 1;
      if (runs == 12) wait (macs_pending == 0);
      case ($urandom_range(0, 15))
        0, 1:    klen = $urandom_range(60, 80);
        2:       klen = $urandom_range(100, 140);
        default: klen = $urandom_range(0, 20);
      endcase
      mlen = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 30);
      if ($urandom_range(0, 7) == 0) send(CMD_NOP, pick_byte());
      mac_run(klen, mlen, $urandom_range(0, 3) == 0);
    end
    s_axis_tvalid <= 0;
    no_stall = 0;

    wait (macs_pending == 0);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/hmac_pkg.sv
design/hmac_sha_core.sv
design/hmac_sha256_engine.sv
design/hmac_checker.sv
bench/hmac_mac_checker.sv
bench/tb_top.sv
